[hw/rtl/v3fx_pkg.sv]
// Package for the three-component fixed-point vector unit.
// Holds the payload types, opcode and fault codes and the saturation helper.
// No dependencies.
package v3fx_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DOT_W     = PROD_W - FRAC_W;
    localparam int QN_W      = DATA_W + FRAC_W;
    localparam int SQ_STEPS  = DATA_W;
    localparam int DIV_STEPS = QN_W;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_SCALE  = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_EQUAL  = 4'd4;
    localparam logic [3:0] OP_SELECT = 4'd5;
    localparam logic [3:0] OP_LENGTH = 4'd6;
    localparam logic [3:0] OP_NORM   = 4'd7;
    localparam logic [3:0] OP_DOT    = 4'd8;
    localparam logic [3:0] OP_CROSS  = 4'd9;

    localparam logic [1:0] FLT_OK    = 2'd0;
    localparam logic [1:0] FLT_ZERO  = 2'd1;
    localparam logic [1:0] FLT_INDEX = 2'd2;

    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] scalar_in;
        logic [1:0]               component_index;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_x;
        logic signed [DATA_W-1:0] r_y;
        logic signed [DATA_W-1:0] r_z;
        logic signed [DATA_W-1:0] r_scalar;
        logic                     is_equal;
        logic [1:0]               fault;
    } out_t;

    typedef struct packed {
        logic [3:0]               op;
        out_t                     res;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] s;
    } ctl_t;

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        hi = {1'b0, {(DATA_W-1){1'b1}}};
        lo = {1'b1, {(DATA_W-1){1'b0}}};
        if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1]))
            return v[DATA_W-1:0];
        else if (v[PROD_W-1])
            return lo;
        else
            return hi;
    endfunction

endpackage

[hw/rtl/v3fx_lane.sv]
// One vector lane: two registered multipliers and the per-lane combine stage.
// Depends on v3fx_pkg.
module v3fx_lane (
    input  logic                               clk,
    input  logic                               en,
    input  logic [3:0]                         op,
    input  logic signed [v3fx_pkg::DATA_W-1:0] a_i,
    input  logic signed [v3fx_pkg::DATA_W-1:0] b_i,
    input  logic signed [v3fx_pkg::DATA_W-1:0] a_j,
    input  logic signed [v3fx_pkg::DATA_W-1:0] b_j,
    input  logic signed [v3fx_pkg::DATA_W-1:0] a_k,
    input  logic signed [v3fx_pkg::DATA_W-1:0] b_k,
    input  logic signed [v3fx_pkg::DATA_W-1:0] s,
    output logic signed [v3fx_pkg::DATA_W-1:0] vec_q,
    output logic signed [v3fx_pkg::DOT_W-1:0]  dot_t,
    output logic [v3fx_pkg::PROD_W-1:0]        sq
);
    import v3fx_pkg::*;

    logic signed [DATA_W-1:0] m0a;
    logic signed [DATA_W-1:0] m0b;
    logic signed [PROD_W-1:0] m0_next;
    logic signed [PROD_W-1:0] m1_next;
    logic signed [PROD_W-1:0] m0_reg;
    logic signed [PROD_W-1:0] m1_reg;
    logic [3:0]               op_reg;
    logic signed [PROD_W:0]   diff;
    logic signed [PROD_W:0]   diff_sh;
    logic signed [PROD_W-1:0] m0_sh;
    logic signed [DATA_W-1:0] vec_next;
    logic signed [DATA_W-1:0] vec_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [PROD_W-1:0]        sq_reg;

    always_comb
    begin
        m0a = a_i;
        m0b = s;
        case (op)
            OP_DOT:
            begin
                m0b = b_i;
            end
            OP_CROSS:
            begin
                m0a = a_j;
                m0b = b_k;
            end
            OP_LENGTH, OP_NORM:
            begin
                m0b = a_i;
            end
            default:
            begin
                m0b = s;
            end
        endcase
    end

    assign m0_next = m0a * m0b;
    assign m1_next = a_k * b_j;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= m0_next;
            m1_reg <= m1_next;
            op_reg <= op;
        end
    end

    assign m0_sh   = m0_reg >>> FRAC_W;
    assign diff    = (PROD_W + 1)'(m0_reg) - (PROD_W + 1)'(m1_reg);
    assign diff_sh = diff >>> FRAC_W;

    always_comb
    begin
        if (op_reg == OP_SCALE)
            vec_next = sat_word(m0_sh);
        else if (op_reg == OP_CROSS)
            vec_next = sat_word(diff_sh[PROD_W-1:0]);
        else
            vec_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            dot_reg <= m0_sh[DOT_W-1:0];
            sq_reg  <= m0_reg;
        end
    end

    assign vec_q = vec_reg;
    assign dot_t = dot_reg;
    assign sq    = sq_reg;

endmodule

[hw/rtl/v3fx_sqrt.sv]
// Pipelined floor square root, one root bit per stage.
// Depends on v3fx_pkg.
module v3fx_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [v3fx_pkg::PROD_W-1:0] radicand,
    output logic [v3fx_pkg::DATA_W-1:0] root
);
    import v3fx_pkg::*;

    localparam int REM_W = DATA_W + 2;

    logic [REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [DATA_W-1:0] root_reg [SQ_STEPS];
    logic [PROD_W-1:0] v_reg    [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [DATA_W-1:0] root_in;
        logic [PROD_W-1:0] v_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  dif;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = radicand;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign cur   = {rem_in, v_in[PROD_W-1:PROD_W-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign dif   = cur - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? dif[REM_W-1:0] : cur[REM_W-1:0];
                root_reg[k] <= {root_in[DATA_W-2:0], ge};
                v_reg[k]    <= {v_in[PROD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

[hw/rtl/v3fx_div.sv]
// Pipelined signed divider: (num << FRAC_W) / den, truncating, saturated.
// One quotient bit per stage. Depends on v3fx_pkg.
module v3fx_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [v3fx_pkg::DATA_W-1:0] num,
    input  logic [v3fx_pkg::DATA_W-1:0]        den_mag,
    input  logic                               den_neg,
    output logic signed [v3fx_pkg::DATA_W-1:0] q
);
    import v3fx_pkg::*;

    logic [DATA_W-1:0] rem_reg [DIV_STEPS];
    logic [QN_W-1:0]   qn_reg  [DIV_STEPS];
    logic [DATA_W-1:0] den_reg [DIV_STEPS];
    logic              neg_reg [DIV_STEPS];
    logic [DATA_W-1:0] num_mag;
    logic signed [PROD_W-1:0] q_wide;

    assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DATA_W-1:0] rem_in;
        logic [QN_W-1:0]   qn_in;
        logic [DATA_W-1:0] den_in;
        logic              neg_in;
        logic [DATA_W:0]   shifted;
        logic              ge;
        logic [DATA_W:0]   dif;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign qn_in  = {num_mag, {FRAC_W{1'b0}}};
            assign den_in = den_mag;
            assign neg_in = num[DATA_W-1] ^ den_neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign qn_in  = qn_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign shifted = {rem_in, qn_in[QN_W-1]};
        assign ge      = (shifted >= {1'b0, den_in});
        assign dif     = shifted - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? dif[DATA_W-1:0] : shifted[DATA_W-1:0];
                qn_reg[k]  <= {qn_in[QN_W-2:0], ge};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign q_wide = neg_reg[DIV_STEPS-1] ? -$signed(PROD_W'(qn_reg[DIV_STEPS-1]))
                                         : $signed(PROD_W'(qn_reg[DIV_STEPS-1]));
    assign q      = sat_word(q_wide);

endmodule

[hw/rtl/vector3_fixed_point_alu.sv]
// Top level of the three-component Q16.16 vector unit.
// Depends on v3fx_pkg, v3fx_lane, v3fx_sqrt and v3fx_div.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation per transaction: opcode,
//   vectors a and b, scalar_in and component_index.
//   out_valid/out_ready/out_data return exactly one result per transaction,
//   in order: r_x, r_y, r_z, r_scalar, is_equal and fault.
//   Every operation follows the same path: three multiplier lanes, a merge
//   stage, a 32-stage square root and a 48-stage divider bank, then the
//   output register. Throughput is one transaction per cycle while the
//   receiver does not stall.
//   The square root and divider stages, one result bit each, set the latency.
//   When the receiver stalls with a result held, the whole pipeline holds and
//   in_ready drops in the same cycle; it returns as soon as the result is
//   taken.
//   Reset clears every stage valid and the output valid; no data is cleared.
module vector3_fixed_point_alu (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  v3fx_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output v3fx_pkg::out_t  out_data
);
    import v3fx_pkg::*;

    logic en;
    logic acc;

    ctl_t c1_next;
    ctl_t c1_reg;
    ctl_t c2_reg;
    ctl_t c3_next;
    ctl_t c3_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic [PROD_W-1:0] sumsq_next;
    logic [PROD_W-1:0] sumsq_reg;

    ctl_t sq_ctl_reg [SQ_STEPS];
    logic sq_v_reg   [SQ_STEPS];
    ctl_t dv_in;
    ctl_t dv_ctl_reg [DIV_STEPS];
    logic dv_v_reg   [DIV_STEPS];
    ctl_t out_next;
    ctl_t out_reg;
    logic out_valid_reg;

    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DOT_W-1:0]  dot_x;
    logic signed [DOT_W-1:0]  dot_y;
    logic signed [DOT_W-1:0]  dot_z;
    logic [PROD_W-1:0]        sq_x;
    logic [PROD_W-1:0]        sq_y;
    logic [PROD_W-1:0]        sq_z;
    logic signed [PROD_W-1:0] dot_sum;
    logic [DATA_W-1:0]        root;
    logic [DATA_W-1:0]        den_mag;
    logic                     den_neg;
    logic signed [DATA_W-1:0] q_x;
    logic signed [DATA_W-1:0] q_y;
    logic signed [DATA_W-1:0] q_z;
    ctl_t                     sq_last;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign acc      = in_valid && en;

    // Stage 1 control: operations that need no multiplier
    always_comb
    begin
        c1_next     = '0;
        c1_next.op  = in_data.opcode;
        c1_next.a_x = in_data.a_x;
        c1_next.a_y = in_data.a_y;
        c1_next.a_z = in_data.a_z;
        c1_next.s   = in_data.scalar_in;
        case (in_data.opcode)
            OP_ADD:
            begin
                c1_next.res.r_x = sat_word(PROD_W'(in_data.a_x) + PROD_W'(in_data.b_x));
                c1_next.res.r_y = sat_word(PROD_W'(in_data.a_y) + PROD_W'(in_data.b_y));
                c1_next.res.r_z = sat_word(PROD_W'(in_data.a_z) + PROD_W'(in_data.b_z));
            end
            OP_SUB:
            begin
                c1_next.res.r_x = sat_word(PROD_W'(in_data.a_x) - PROD_W'(in_data.b_x));
                c1_next.res.r_y = sat_word(PROD_W'(in_data.a_y) - PROD_W'(in_data.b_y));
                c1_next.res.r_z = sat_word(PROD_W'(in_data.a_z) - PROD_W'(in_data.b_z));
            end
            OP_DIV:
            begin
                if (in_data.scalar_in == '0)
                    c1_next.res.fault = FLT_ZERO;
            end
            OP_EQUAL:
            begin
                c1_next.res.is_equal = (in_data.a_x == in_data.b_x)
                                    && (in_data.a_y == in_data.b_y)
                                    && (in_data.a_z == in_data.b_z);
            end
            OP_SELECT:
            begin
                unique case (in_data.component_index)
                    IDX_X:   c1_next.res.r_scalar = in_data.a_x;
                    IDX_Y:   c1_next.res.r_scalar = in_data.a_y;
                    IDX_Z:   c1_next.res.r_scalar = in_data.a_z;
                    default: c1_next.res.fault    = FLT_INDEX;
                endcase
            end
            default:
            begin
                c1_next.res = '0;
            end
        endcase
    end

    v3fx_lane u_lane_x (
        .clk   (clk),
        .en    (en),
        .op    (in_data.opcode),
        .a_i   (in_data.a_x),
        .b_i   (in_data.b_x),
        .a_j   (in_data.a_y),
        .b_j   (in_data.b_y),
        .a_k   (in_data.a_z),
        .b_k   (in_data.b_z),
        .s     (in_data.scalar_in),
        .vec_q (vec_x),
        .dot_t (dot_x),
        .sq    (sq_x)
    );

    v3fx_lane u_lane_y (
        .clk   (clk),
        .en    (en),
        .op    (in_data.opcode),
        .a_i   (in_data.a_y),
        .b_i   (in_data.b_y),
        .a_j   (in_data.a_z),
        .b_j   (in_data.b_z),
        .a_k   (in_data.a_x),
        .b_k   (in_data.b_x),
        .s     (in_data.scalar_in),
        .vec_q (vec_y),
        .dot_t (dot_y),
        .sq    (sq_y)
    );

    v3fx_lane u_lane_z (
        .clk   (clk),
        .en    (en),
        .op    (in_data.opcode),
        .a_i   (in_data.a_z),
        .b_i   (in_data.b_z),
        .a_j   (in_data.a_x),
        .b_j   (in_data.b_x),
        .a_k   (in_data.a_y),
        .b_k   (in_data.b_y),
        .s     (in_data.scalar_in),
        .vec_q (vec_z),
        .dot_t (dot_z),
        .sq    (sq_z)
    );

    // Merge the lanes
    assign dot_sum    = PROD_W'(dot_x) + PROD_W'(dot_y) + PROD_W'(dot_z);
    assign sumsq_next = sq_x + sq_y + sq_z;

    always_comb
    begin
        c3_next = c2_reg;
        if (c2_reg.op == OP_SCALE || c2_reg.op == OP_CROSS)
        begin
            c3_next.res.r_x = vec_x;
            c3_next.res.r_y = vec_y;
            c3_next.res.r_z = vec_z;
        end
        if (c2_reg.op == OP_DOT)
            c3_next.res.r_scalar = sat_word(dot_sum);
        if (c2_reg.op == OP_NORM && sumsq_next == '0)
            c3_next.res.fault = FLT_ZERO;
    end

    v3fx_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sumsq_reg),
        .root     (root)
    );

    assign sq_last = sq_ctl_reg[SQ_STEPS-1];

    always_comb
    begin
        dv_in = sq_last;
        if (sq_last.op == OP_LENGTH)
            dv_in.res.r_scalar = root[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}}
                                                : $signed(root);
        if (sq_last.op == OP_DIV)
        begin
            den_mag = sq_last.s[DATA_W-1] ? DATA_W'(-sq_last.s) : DATA_W'(sq_last.s);
            den_neg = sq_last.s[DATA_W-1];
        end
        else
        begin
            den_mag = root;
            den_neg = 1'b0;
        end
    end

    v3fx_div u_div_x (
        .clk     (clk),
        .en      (en),
        .num     (sq_last.a_x),
        .den_mag (den_mag),
        .den_neg (den_neg),
        .q       (q_x)
    );

    v3fx_div u_div_y (
        .clk     (clk),
        .en      (en),
        .num     (sq_last.a_y),
        .den_mag (den_mag),
        .den_neg (den_neg),
        .q       (q_y)
    );

    v3fx_div u_div_z (
        .clk     (clk),
        .en      (en),
        .num     (sq_last.a_z),
        .den_mag (den_mag),
        .den_neg (den_neg),
        .q       (q_z)
    );

    always_comb
    begin
        out_next = dv_ctl_reg[DIV_STEPS-1];
        if ((out_next.op == OP_DIV || out_next.op == OP_NORM) && out_next.res.fault == FLT_OK)
        begin
            out_next.res.r_x = q_x;
            out_next.res.r_y = q_y;
            out_next.res.r_z = q_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= acc;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            sq_v_reg[0] <= v3_reg;
            for (int k = 1; k < SQ_STEPS; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS-1];
            for (int k = 1; k < DIV_STEPS; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
            out_valid_reg <= dv_v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg        <= c1_next;
            c2_reg        <= c1_reg;
            c3_reg        <= c3_next;
            sumsq_reg     <= sumsq_next;
            sq_ctl_reg[0] <= c3_reg;
            for (int k = 1; k < SQ_STEPS; k++)
                sq_ctl_reg[k] <= sq_ctl_reg[k-1];
            dv_ctl_reg[0] <= dv_in;
            for (int k = 1; k < DIV_STEPS; k++)
                dv_ctl_reg[k] <= dv_ctl_reg[k-1];
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg.res;

`ifndef SYNTH
    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled without a held result");

    a_zero_fault_op: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fault == FLT_ZERO)
            |-> (out_reg.op == OP_DIV || out_reg.op == OP_NORM))
        else $error("zero-divisor fault on an operation without division");

    a_fault_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fault != FLT_OK)
            |-> (out_data.r_x == '0 && out_data.r_y == '0
                 && out_data.r_z == '0 && out_data.r_scalar == '0))
        else $error("faulted transaction carries non-zero results");
`endif

endmodule

[verif/vector3_fixed_point_alu_test.sv]
// Self-checking testbench for the Q16.16 three-component vector unit.
// Drives random and directed transactions and checks each result against an in-bench model.
// Depends on v3fx_pkg and vector3_fixed_point_alu.
module vector3_fixed_point_alu_test;
    import v3fx_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    in_t  pending_ops[$];
    out_t expected_results[$];
    int   mismatches;
    int   accepted_ops;
    int   queued_ops;
    bit   stim_done;
    int   hold_off;
    int   recv_gap;
    int   send_gap;
    bit   in_ready_taken;
    bit   out_taken;

    vector3_fixed_point_alu dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bit_w;
        res = 0;
        bit_w = 128'd1 << 126;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res[63:0];
    endfunction

    function automatic out_t vector_result(input in_t t);
        out_t r;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] s;
        logic signed [127:0] v[3];
        logic signed [127:0] sc;
        logic signed [127:0] len;
        r = '0;
        a[0] = t.a_x; a[1] = t.a_y; a[2] = t.a_z;
        b[0] = t.b_x; b[1] = t.b_y; b[2] = t.b_z;
        s = t.scalar_in;
        v[0] = 0; v[1] = 0; v[2] = 0;
        sc = 0;
        case (t.opcode)
            OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            OP_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FRAC_W;
            OP_DIV:
                if (s == 0)
                    r.fault = FLT_ZERO;
                else
                    for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_W) / s;
            OP_EQUAL: r.is_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            OP_SELECT:
                if (t.component_index == 2'd3)
                    r.fault = FLT_INDEX;
                else
                    sc = a[t.component_index];
            OP_LENGTH, OP_NORM:
            begin
                len = $signed({64'd0, root_floor(a[0]*a[0] + a[1]*a[1] + a[2]*a[2])});
                if (t.opcode == OP_LENGTH)
                    sc = len;
                else if (len == 0)
                    r.fault = FLT_ZERO;
                else
                    for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_W) / len;
            end
            OP_DOT: sc = ((a[0]*b[0]) >>> FRAC_W) + ((a[1]*b[1]) >>> FRAC_W)
                       + ((a[2]*b[2]) >>> FRAC_W);
            OP_CROSS:
            begin
                v[0] = (a[1]*b[2] - a[2]*b[1]) >>> FRAC_W;
                v[1] = (a[2]*b[0] - a[0]*b[2]) >>> FRAC_W;
                v[2] = (a[0]*b[1] - a[1]*b[0]) >>> FRAC_W;
            end
            default: ;
        endcase
        r.r_x = clamp32(v[0]);
        r.r_y = clamp32(v[1]);
        r.r_z = clamp32(v[2]);
        r.r_scalar = clamp32(sc);
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5: return $urandom_range(0, 255);
            6, 7: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t random_op();
        in_t t;
        t.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
        t.a_x = pick_word(); t.a_y = pick_word(); t.a_z = pick_word();
        t.b_x = pick_word(); t.b_y = pick_word(); t.b_z = pick_word();
        t.scalar_in = pick_word();
        t.component_index = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0)
        begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            t.a_x = 0; t.a_y = 0; t.a_z = 0; t.scalar_in = 0;
        end
        return t;
    endfunction

    function automatic in_t make_op(input logic [3:0] op, input logic [31:0] av,
                                    input logic [31:0] bv, input logic [31:0] sv,
                                    input logic [1:0] idx);
        in_t t;
        t.opcode = op;
        t.a_x = av; t.a_y = ~av; t.a_z = av;
        t.b_x = bv; t.b_y = bv; t.b_z = ~bv;
        t.scalar_in = sv;
        t.component_index = idx;
        return t;
    endfunction

    task automatic queue_op(input in_t t);
        pending_ops.push_back(t);
        queued_ops++;
    endtask

    initial
    begin
        in_t t;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        accepted_ops = 0;
        queued_ops = 0;
        stim_done = 1'b0;
        recv_gap = 0;
        send_gap = 0;
        for (int op = 0; op < 16; op++)
            queue_op(make_op(4'(op), 32'h7fffffff, 32'h80000000,
                             32'h80000000, IDX_Y));
        queue_op(make_op(OP_DIV, 32'h00030000, 32'h1, 32'h0, IDX_X));
        t = make_op(OP_NORM, 32'h0, 32'h0, 32'h0, IDX_X);
        t.a_y = 0;
        queue_op(t);
        queue_op(make_op(OP_SELECT, 32'h12345678, 32'h0, 32'h0, 2'd3));
        queue_op(make_op(OP_SELECT, 32'h12345678, 32'h0, 32'h0, IDX_Z));
        queue_op(make_op(OP_SELECT, 32'h12345678, 32'h0, 32'h0, IDX_X));
        t = make_op(OP_EQUAL, 32'h55aa55aa, 32'h0, 32'h0, IDX_X);
        t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        queue_op(t);
        queue_op(make_op(OP_LENGTH, 32'h80000000, 32'h0, 32'h0, IDX_X));
        queue_op(make_op(OP_SCALE, 32'hffffffff, 32'h0, 32'hffffffff, IDX_X));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 350; i++)
            queue_op(random_op());
        while (accepted_ops != queued_ops || expected_results.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 380; i++)
            queue_op(random_op());
        stim_done = 1'b1;
    end

    initial
    begin
        hold_off = 0;
        wait (accepted_ops >= 200);
        @(negedge clk);
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    in_data <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                end
                else
                    in_valid <= 1'b0;
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_taken)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        out_t got;
        out_t want;
        in_ready_taken <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(vector_result(in_data));
            accepted_ops <= accepted_ops + 1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = out_data;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp x=%h y=%h z=%h s=%h eq=%b f=%0d",
                                 want.r_x, want.r_y, want.r_z, want.r_scalar,
                                 want.is_equal, want.fault,
                                 " got x=%h y=%h z=%h s=%h eq=%b f=%0d",
                                 got.r_x, got.r_y, got.r_z, got.r_scalar,
                                 got.is_equal, got.fault);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (accepted_ops != queued_ops || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/v3fx_pkg.sv
hw/rtl/v3fx_lane.sv
hw/rtl/v3fx_sqrt.sv
hw/rtl/v3fx_div.sv
hw/rtl/vector3_fixed_point_alu.sv
verif/vector3_fixed_point_alu_test.sv
